// ----- src/tlssni_pkg.sv -----
`timescale 1ns / 1ps

package tlssni_pkg;

  // position counters and the wider sums used in bound checks
  localparam int CNT_W = 24;
  localparam int PW    = CNT_W + 1;
  localparam int HE_W  = ((CNT_W > 24) ? CNT_W : 24) + 1;

  localparam logic [7:0]  REC_TYPE_HANDSHAKE   = 8'd22;
  localparam logic [7:0]  HS_TYPE_CLIENT_HELLO = 8'd1;
  localparam logic [2:0]  REC_HDR_LAST         = 3'd4;
  localparam logic [2:0]  HS_HDR_LAST          = 3'd3;
  localparam logic [2:0]  REC_LEN_HI           = 3'd3;
  localparam logic [2:0]  REC_LEN_LO           = 3'd4;
  localparam logic [15:0] FIXED_LEN            = 16'd34;
  localparam logic [15:0] SNI_TYPE             = 16'd0;
  localparam int          HDR_BYTES            = 9;
  localparam int          REC_HDR_BYTES        = 5;

  // result queue
  localparam int RQ_DEPTH = 8;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);
  localparam int RQ_CW    = RQ_AW + 1;

  localparam logic RES_NAME   = 1'b0;
  localparam logic RES_STATUS = 1'b1;

  typedef enum logic [4:0] {
    PH_REC,
    PH_HS,
    PH_SKIP_FIXED,
    PH_SID_LEN,
    PH_SKIP_SID,
    PH_CS_LEN,
    PH_SKIP_CS,
    PH_COMP_LEN,
    PH_SKIP_COMP,
    PH_EXT_TOTAL,
    PH_EXT_TYPE,
    PH_EXT_LEN,
    PH_SKIP_EXT,
    PH_SNL_LEN,
    PH_NAME_TYPE,
    PH_NAME_LEN,
    PH_NAME_SKIP,
    PH_NAME_OUT,
    PH_END
  } phase_t;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_HELLO = 2'd1,
    ST_NO_NAME   = 2'd2,
    ST_MALFORMED = 2'd3
  } status_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] name_byte;
    logic       name_end;
    status_t    status;
  } result_t;

  typedef struct packed {
    logic    a_vld;
    result_t a;
    logic    b_vld;
    result_t b;
  } res_pair_t;

endpackage

// ----- src/tls_client_hello_sni_extract.sv -----
`timescale 1ns / 1ps

// Server-name extractor for TLS ClientHello buffers. Feed the buffer one byte
// per word with tlast on its final byte; a new byte can be taken in every cycle
// that in_tready is high. Each byte is registered, then parsed in the following
// cycle by counter and compare logic, and its results go into an eight-word
// result queue. A byte of the host name gives one word, the final byte of a
// buffer gives a status word (and, when it is also the last name byte, the
// name word first). in_tready drops while the queue holds more than four
// words, so with out_tready held high the block runs at one byte per cycle;
// output stalls reach in_tready only once more than four words are waiting.
module tls_client_hello_sni_extract (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] name_byte, [9:8] status, [15:10] zero
  output logic        out_tlast,  // name_end
  output logic [0:0]  out_tuser   // [0] result_kind
);
  import tlssni_pkg::*;

  logic      in_vld_r;
  logic [7:0] in_byte_r;
  logic      in_last_r;
  res_pair_t res;
  result_t   head;
  logic      room;
  logic      not_empty;

  assign in_tready = room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_tvalid && in_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  tlssni_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_vld  (in_vld_r),
    .item_byte (in_byte_r),
    .item_last (in_last_r),
    .res       (res)
  );

  tlssni_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res),
    .pop       (out_tready),
    .not_empty (not_empty),
    .room      (room),
    .head      (head)
  );

  assign out_tvalid = not_empty;
  assign out_tdata  = {6'd0, head.status, head.name_byte};
  assign out_tlast  = head.name_end;
  assign out_tuser  = head.kind;

endmodule

// ----- src/tlssni_parser.sv -----
`timescale 1ns / 1ps

module tlssni_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  item_vld,
  input  logic [7:0]            item_byte,
  input  logic                  item_last,
  output tlssni_pkg::res_pair_t res
);
  import tlssni_pkg::*;

  phase_t             phase_r,    phase_nxt;
  logic [2:0]         fcnt_r,     fcnt_nxt;
  logic [23:0]        accum_r,    accum_nxt;
  logic [CNT_W-1:0]   seen_r,     seen_nxt;
  logic [15:0]        rec_len_r,  rec_len_nxt;
  logic [CNT_W-1:0]   hs_end_r,   hs_end_nxt;
  logic [15:0]        skip_r,     skip_nxt;
  logic [15:0]        ext_type_r, ext_type_nxt;
  logic [CNT_W-1:0]   list_end_r, list_end_nxt;
  logic [15:0]        name_rem_r, name_rem_nxt;
  status_t            perr_r,     perr_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_REC;
      fcnt_r     <= '0;
      accum_r    <= '0;
      seen_r     <= '0;
      rec_len_r  <= '0;
      hs_end_r   <= '0;
      skip_r     <= '0;
      ext_type_r <= '0;
      list_end_r <= '0;
      name_rem_r <= '0;
      perr_r     <= ST_FOUND;
    end else begin
      phase_r    <= phase_nxt;
      fcnt_r     <= fcnt_nxt;
      accum_r    <= accum_nxt;
      seen_r     <= seen_nxt;
      rec_len_r  <= rec_len_nxt;
      hs_end_r   <= hs_end_nxt;
      skip_r     <= skip_nxt;
      ext_type_r <= ext_type_nxt;
      list_end_r <= list_end_nxt;
      name_rem_r <= name_rem_nxt;
      perr_r     <= perr_nxt;
    end
  end

  logic [PW-1:0]    pn;
  logic [PW-1:0]    pos_w;
  logic [23:0]      acc_new;
  logic [15:0]      fv;
  logic [HE_W-1:0]  he_sum;
  logic [PW-1:0]    sum;
  logic [PW-1:0]    lim;
  logic             one_byte;
  logic             do_skip;
  logic [15:0]      sk_len;
  phase_t           sk_ph;
  logic [CNT_W-1:0] sk_lim;
  logic             do_fin;
  phase_t           fin_ph;
  logic             do_names;
  logic             do_ext;
  logic [15:0]      cnt_dec;
  result_t          name_res;
  result_t          stat_res;
  logic             name_vld;
  status_t          st;

  always_comb begin
    phase_nxt    = phase_r;
    fcnt_nxt     = fcnt_r;
    accum_nxt    = accum_r;
    seen_nxt     = seen_r;
    rec_len_nxt  = rec_len_r;
    hs_end_nxt   = hs_end_r;
    skip_nxt     = skip_r;
    ext_type_nxt = ext_type_r;
    list_end_nxt = list_end_r;
    name_rem_nxt = name_rem_r;
    perr_nxt     = perr_r;

    pos_w    = {1'b0, seen_r};
    pn       = pos_w + PW'(1);
    acc_new  = {accum_r[15:0], item_byte};
    fv       = acc_new[15:0];
    he_sum   = HE_W'(acc_new) + HE_W'(HDR_BYTES);
    sum      = pn + PW'(fv);
    one_byte = (phase_r == PH_SID_LEN) || (phase_r == PH_COMP_LEN) ||
               (phase_r == PH_NAME_TYPE);
    lim      = ((phase_r == PH_NAME_TYPE) || (phase_r == PH_NAME_LEN)) ?
               {1'b0, list_end_r} : {1'b0, hs_end_r};
    cnt_dec  = '0;
    do_skip  = 1'b0;
    sk_len   = '0;
    sk_ph    = PH_SKIP_FIXED;
    sk_lim   = hs_end_r;
    do_fin   = 1'b0;
    fin_ph   = PH_SKIP_FIXED;
    do_names = 1'b0;
    do_ext   = 1'b0;
    name_vld = 1'b0;
    name_res = '{kind: RES_NAME, name_byte: item_byte,
                 name_end: (name_rem_r <= 16'd1), status: ST_FOUND};
    stat_res = '{kind: RES_STATUS, name_byte: 8'd0, name_end: 1'b0, status: ST_FOUND};
    st       = ST_MALFORMED;

    if (item_vld) begin
      seen_nxt = pn[CNT_W] ? {CNT_W{1'b1}} : pn[CNT_W-1:0];
      case (phase_r)
        PH_REC: begin
          if (fcnt_r == 3'd0 && item_byte != REC_TYPE_HANDSHAKE) begin
            phase_nxt = PH_END;
            perr_nxt  = ST_NOT_HELLO;
          end else begin
            if (fcnt_r == REC_LEN_HI) rec_len_nxt = {item_byte, 8'h00};
            if (fcnt_r == REC_LEN_LO) rec_len_nxt = {rec_len_r[15:8], item_byte};
            fcnt_nxt = fcnt_r + 3'd1;
            if (fcnt_r == REC_HDR_LAST) begin
              phase_nxt = PH_HS;
              fcnt_nxt  = '0;
              accum_nxt = '0;
            end
          end
        end
        PH_HS: begin
          if (fcnt_r == 3'd0) begin
            if (item_byte != HS_TYPE_CLIENT_HELLO) begin
              phase_nxt = PH_END;
              perr_nxt  = ST_NOT_HELLO;
            end else begin
              fcnt_nxt  = 3'd1;
              accum_nxt = '0;
            end
          end else begin
            accum_nxt = acc_new;
            fcnt_nxt  = fcnt_r + 3'd1;
            if (fcnt_r == HS_HDR_LAST) begin
              hs_end_nxt = (he_sum > HE_W'({CNT_W{1'b1}})) ? {CNT_W{1'b1}} :
                           he_sum[CNT_W-1:0];
              do_skip = 1'b1;
              sk_len  = FIXED_LEN;
              sk_ph   = PH_SKIP_FIXED;
              sk_lim  = hs_end_nxt;
            end
          end
        end
        PH_SKIP_FIXED, PH_SKIP_SID, PH_SKIP_CS, PH_SKIP_COMP, PH_SKIP_EXT,
        PH_NAME_SKIP: begin
          cnt_dec  = skip_r - {15'd0, (skip_r != 16'd0)};
          skip_nxt = cnt_dec;
          if (cnt_dec == 16'd0) begin
            do_fin = 1'b1;
            fin_ph = phase_r;
          end
        end
        PH_NAME_OUT: begin
          name_vld     = 1'b1;
          cnt_dec      = name_rem_r - {15'd0, (name_rem_r != 16'd0)};
          name_rem_nxt = cnt_dec;
          if (cnt_dec == 16'd0) begin
            phase_nxt = PH_END;
            perr_nxt  = ST_FOUND;
          end
        end
        PH_END: begin
        end
        default: begin
          // length and type fields of one or two bytes
          if (fcnt_r == 3'd0 && (pos_w + (one_byte ? PW'(1) : PW'(2))) > lim) begin
            phase_nxt = PH_END;
            perr_nxt  = ST_MALFORMED;
          end else begin
            accum_nxt = acc_new;
            fcnt_nxt  = fcnt_r + 3'd1;
            if (one_byte || fcnt_r == 3'd1) begin
              case (phase_r)
                PH_SID_LEN: begin
                  do_skip = 1'b1; sk_len = fv; sk_ph = PH_SKIP_SID;
                end
                PH_CS_LEN: begin
                  do_skip = 1'b1; sk_len = fv; sk_ph = PH_SKIP_CS;
                end
                PH_COMP_LEN: begin
                  do_skip = 1'b1; sk_len = fv; sk_ph = PH_SKIP_COMP;
                end
                PH_EXT_TOTAL: do_ext = 1'b1;
                PH_EXT_TYPE: begin
                  ext_type_nxt = fv;
                  phase_nxt    = PH_EXT_LEN;
                  fcnt_nxt     = '0;
                  accum_nxt    = '0;
                end
                PH_EXT_LEN: begin
                  if (ext_type_r == SNI_TYPE) begin
                    phase_nxt = PH_SNL_LEN;
                    fcnt_nxt  = '0;
                    accum_nxt = '0;
                  end else begin
                    do_skip = 1'b1; sk_len = fv; sk_ph = PH_SKIP_EXT;
                  end
                end
                PH_SNL_LEN: begin
                  if (sum > {1'b0, hs_end_r}) begin
                    phase_nxt = PH_END;
                    perr_nxt  = ST_MALFORMED;
                  end else begin
                    list_end_nxt = sum[CNT_W-1:0];
                    do_names     = 1'b1;
                  end
                end
                PH_NAME_TYPE: begin
                  ext_type_nxt = fv;
                  phase_nxt    = PH_NAME_LEN;
                  fcnt_nxt     = '0;
                  accum_nxt    = '0;
                end
                default: begin
                  if (sum > {1'b0, list_end_r}) begin
                    phase_nxt = PH_END;
                    perr_nxt  = ST_MALFORMED;
                  end else if (ext_type_r == SNI_TYPE) begin
                    if (fv == 16'd0) begin
                      phase_nxt = PH_END;
                      perr_nxt  = ST_FOUND;
                    end else begin
                      name_rem_nxt = fv;
                      phase_nxt    = PH_NAME_OUT;
                    end
                  end else begin
                    do_skip = 1'b1; sk_len = fv; sk_ph = PH_NAME_SKIP;
                    sk_lim  = list_end_r;
                  end
                end
              endcase
            end
          end
        end
      endcase

      if (do_skip) begin
        if ((pn + PW'(sk_len)) > {1'b0, sk_lim}) begin
          phase_nxt = PH_END;
          perr_nxt  = ST_MALFORMED;
        end else if (sk_len == 16'd0) begin
          do_fin = 1'b1;
          fin_ph = sk_ph;
        end else begin
          skip_nxt  = sk_len;
          phase_nxt = sk_ph;
        end
      end

      if (do_fin) begin
        case (fin_ph)
          PH_SKIP_FIXED: begin
            phase_nxt = PH_SID_LEN; fcnt_nxt = '0; accum_nxt = '0;
          end
          PH_SKIP_SID: begin
            phase_nxt = PH_CS_LEN; fcnt_nxt = '0; accum_nxt = '0;
          end
          PH_SKIP_CS: begin
            phase_nxt = PH_COMP_LEN; fcnt_nxt = '0; accum_nxt = '0;
          end
          PH_SKIP_COMP: begin
            if (pn >= {1'b0, hs_end_nxt}) begin
              phase_nxt = PH_END;
              perr_nxt  = ST_NO_NAME;
            end else begin
              phase_nxt = PH_EXT_TOTAL; fcnt_nxt = '0; accum_nxt = '0;
            end
          end
          PH_SKIP_EXT: do_ext = 1'b1;
          default:     do_names = 1'b1;
        endcase
      end

      if (do_names) begin
        if (pn >= {1'b0, list_end_nxt}) begin
          do_ext = 1'b1;
        end else begin
          phase_nxt = PH_NAME_TYPE; fcnt_nxt = '0; accum_nxt = '0;
        end
      end

      if (do_ext) begin
        if (pn >= {1'b0, hs_end_nxt}) begin
          phase_nxt = PH_END;
          perr_nxt  = ST_NO_NAME;
        end else begin
          phase_nxt = PH_EXT_TYPE; fcnt_nxt = '0; accum_nxt = '0;
        end
      end

      if (item_last) begin
        if (phase_nxt == PH_REC || phase_nxt == PH_HS) begin
          st = ST_NOT_HELLO;
        end else if (phase_nxt == PH_END && perr_nxt == ST_NOT_HELLO) begin
          st = ST_NOT_HELLO;
        end else if ((PW'(rec_len_nxt) + PW'(REC_HDR_BYTES)) > {1'b0, seen_nxt}) begin
          st = ST_NOT_HELLO;
        end else if (phase_nxt == PH_END) begin
          st = perr_nxt;
        end else begin
          st = ST_MALFORMED;
        end
        // back to the record header for the next buffer
        phase_nxt    = PH_REC;
        fcnt_nxt     = '0;
        accum_nxt    = '0;
        seen_nxt     = '0;
        rec_len_nxt  = '0;
        hs_end_nxt   = '0;
        skip_nxt     = '0;
        ext_type_nxt = '0;
        list_end_nxt = '0;
        name_rem_nxt = '0;
        perr_nxt     = ST_FOUND;
      end
    end

    stat_res.status = st;
    res.a_vld = name_vld || (item_vld && item_last);
    res.a     = name_vld ? name_res : stat_res;
    res.b_vld = name_vld && item_vld && item_last;
    res.b     = stat_res;
  end

endmodule

// ----- src/tlssni_res_fifo.sv -----
`timescale 1ns / 1ps

module tlssni_res_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tlssni_pkg::res_pair_t push,
  input  logic                  pop,
  output logic                  not_empty,
  output logic                  room,
  output tlssni_pkg::result_t   head
);
  import tlssni_pkg::*;

  result_t          mem_r [RQ_DEPTH];
  logic [RQ_AW-1:0] wp_r, wp_nxt;
  logic [RQ_AW-1:0] rp_r, rp_nxt;
  logic [RQ_CW-1:0] cnt_r, cnt_nxt;
  logic [RQ_AW-1:0] wp_b;
  logic             do_pop;

  assign do_pop    = pop && (cnt_r != '0);
  assign wp_b      = wp_r + RQ_AW'(push.a_vld);
  assign wp_nxt    = wp_r + RQ_AW'(push.a_vld) + RQ_AW'(push.b_vld);
  assign rp_nxt    = rp_r + RQ_AW'(do_pop);
  assign cnt_nxt   = cnt_r + RQ_CW'(push.a_vld) + RQ_CW'(push.b_vld) - RQ_CW'(do_pop);
  assign not_empty = (cnt_r != '0);
  // the held word and a new one may each add two
  assign room      = (cnt_r <= RQ_CW'(RQ_DEPTH - 4));
  assign head      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.a_vld) mem_r[wp_r] <= push.a;
    if (push.b_vld) mem_r[wp_b] <= push.b;
  end

endmodule

// ----- src/tlssni_checker.sv -----
`timescale 1ns / 1ps

module tlssni_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast,
  input logic [0:0]  out_tuser
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tlast) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // status words carry no name byte or name end
  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[7:0] == 8'd0 && !out_tlast)
    else $error("status word carries name fields");

  // name words carry a zero status
  a_name_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[9:8] == 2'd0)
    else $error("name word carries a status");

  // a status can only follow an accepted last byte
  a_status_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) && out_tuser[0] |-> $past(in_tvalid && in_tready && in_tlast, 2) ||
                                          $past(out_tvalid, 1))
    else $error("status word without a last byte");

endmodule

bind tls_client_hello_sni_extract tlssni_checker u_tlssni_checker (.*);

// ----- test/tlssni_check.sv -----
`timescale 1ns / 1ps

module tlssni_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // [7:0] name_byte, [9:8] status, [15:10] zero
  input  logic        out_tlast,  // name_end
  input  logic [0:0]  out_tuser,  // [0] result_kind
  output int          fail_count,
  output int          words_due
);
  import tlssni_pkg::*;

  localparam logic [63:0] POS_MAX        = (64'd1 << CNT_W) - 64'd1;
  localparam logic [15:0] HOST_NAME_TYPE = 16'd0;
  localparam int          MAX_REPORTS    = 10;

  // parser state as it should be after every accepted byte
  phase_t           ph;
  logic [2:0]       fcnt;
  logic [23:0]      facc;
  logic [CNT_W-1:0] seen;
  logic [15:0]      rec_len;
  logic [CNT_W-1:0] hs_end;
  logic [15:0]      skip_left;
  logic [15:0]      cur_type;
  logic [CNT_W-1:0] lst_end;
  logic [15:0]      name_left;
  status_t          held_status;

  result_t sni_words_due[$];
  int      fails;

  function automatic void clear_parser();
    ph          = PH_REC;
    fcnt        = '0;
    facc        = '0;
    seen        = '0;
    rec_len     = '0;
    hs_end      = '0;
    skip_left   = '0;
    cur_type    = '0;
    lst_end     = '0;
    name_left   = '0;
    held_status = ST_FOUND;
  endfunction

  function automatic void end_with(input status_t s);
    ph          = PH_END;
    held_status = s;
  endfunction

  function automatic void open_field(input phase_t p);
    ph   = p;
    fcnt = '0;
    facc = '0;
  endfunction

  function automatic void to_ext(input logic [63:0] pos);
    if (pos >= hs_end) end_with(ST_NO_NAME);
    else open_field(PH_EXT_TYPE);
  endfunction

  function automatic void to_names(input logic [63:0] pos);
    if (pos >= lst_end) to_ext(pos);
    else open_field(PH_NAME_TYPE);
  endfunction

  function automatic void skip_done(input phase_t p, input logic [63:0] pos);
    case (p)
      PH_SKIP_FIXED: open_field(PH_SID_LEN);
      PH_SKIP_SID:   open_field(PH_CS_LEN);
      PH_SKIP_CS:    open_field(PH_COMP_LEN);
      PH_SKIP_COMP: begin
        if (pos >= hs_end) end_with(ST_NO_NAME);
        else open_field(PH_EXT_TOTAL);
      end
      PH_SKIP_EXT:   to_ext(pos);
      default:       to_names(pos);
    endcase
  endfunction

  function automatic void begin_skip(input logic [63:0] pos, input logic [63:0] len,
                                     input phase_t p, input logic [63:0] limit);
    if (pos + len > limit) end_with(ST_MALFORMED);
    else if (len == 0) skip_done(p, pos);
    else begin
      skip_left = len[15:0];
      ph        = p;
    end
  endfunction

  // advance the parser by one byte and queue the words it should produce
  function automatic void parse_byte(input logic [7:0] b, input logic last);
    logic [63:0] pos, pn, he, v, lim, sum;
    int          w;
    result_t     r;
    status_t     st;
    phase_t      cur;
    pos  = 64'(seen);
    pn   = pos + 64'd1;
    seen = (pn > POS_MAX) ? POS_MAX[CNT_W-1:0] : pn[CNT_W-1:0];
    cur  = ph;
    case (cur)
      PH_REC: begin
        if (fcnt == 0 && b != REC_TYPE_HANDSHAKE) end_with(ST_NOT_HELLO);
        else begin
          if (fcnt == REC_LEN_HI) rec_len = {b, 8'h00};
          if (fcnt == REC_LEN_LO) rec_len = rec_len | {8'h00, b};
          fcnt++;
          if (fcnt > REC_HDR_LAST) open_field(PH_HS);
        end
      end
      PH_HS: begin
        if (fcnt == 0) begin
          if (b != HS_TYPE_CLIENT_HELLO) end_with(ST_NOT_HELLO);
          else begin
            fcnt = 3'd1;
            facc = '0;
          end
        end else begin
          facc = {facc[15:0], b};
          fcnt++;
          if (fcnt > HS_HDR_LAST) begin
            he     = 64'(HDR_BYTES) + 64'(facc);
            hs_end = (he > POS_MAX) ? POS_MAX[CNT_W-1:0] : he[CNT_W-1:0];
            begin_skip(pn, 64'(FIXED_LEN), PH_SKIP_FIXED, 64'(hs_end));
          end
        end
      end
      PH_SKIP_FIXED, PH_SKIP_SID, PH_SKIP_CS, PH_SKIP_COMP, PH_SKIP_EXT, PH_NAME_SKIP: begin
        if (skip_left > 0) skip_left--;
        if (skip_left == 0) skip_done(cur, pn);
      end
      PH_NAME_OUT: begin
        r.kind      = RES_NAME;
        r.name_byte = b;
        r.name_end  = (name_left <= 16'd1);
        r.status    = ST_FOUND;
        sni_words_due.push_back(r);
        if (name_left > 0) name_left--;
        if (name_left == 0) end_with(ST_FOUND);
      end
      PH_END: ;
      default: begin
        w   = (cur == PH_SID_LEN || cur == PH_COMP_LEN || cur == PH_NAME_TYPE) ? 1 : 2;
        lim = (cur == PH_NAME_TYPE || cur == PH_NAME_LEN) ? 64'(lst_end) : 64'(hs_end);
        if (fcnt == 0 && pos + w > lim) end_with(ST_MALFORMED);
        else begin
          facc = {facc[15:0], b};
          fcnt++;
          if (fcnt >= w) begin
            v   = 64'(facc);
            sum = pn + v;
            case (cur)
              PH_SID_LEN:   begin_skip(pn, v, PH_SKIP_SID, 64'(hs_end));
              PH_CS_LEN:    begin_skip(pn, v, PH_SKIP_CS, 64'(hs_end));
              PH_COMP_LEN:  begin_skip(pn, v, PH_SKIP_COMP, 64'(hs_end));
              PH_EXT_TOTAL: to_ext(pn);
              PH_EXT_TYPE: begin
                cur_type = v[15:0];
                open_field(PH_EXT_LEN);
              end
              PH_EXT_LEN: begin
                if (cur_type == SNI_TYPE) open_field(PH_SNL_LEN);
                else begin_skip(pn, v, PH_SKIP_EXT, 64'(hs_end));
              end
              PH_SNL_LEN: begin
                if (sum > hs_end) end_with(ST_MALFORMED);
                else begin
                  lst_end = sum[CNT_W-1:0];
                  to_names(pn);
                end
              end
              PH_NAME_TYPE: begin
                cur_type = v[15:0];
                open_field(PH_NAME_LEN);
              end
              default: begin
                if (sum > lst_end) end_with(ST_MALFORMED);
                else if (cur_type == HOST_NAME_TYPE) begin
                  if (v == 0) end_with(ST_FOUND);
                  else begin
                    name_left = v[15:0];
                    ph        = PH_NAME_OUT;
                  end
                end else begin
                  begin_skip(pn, v, PH_NAME_SKIP, 64'(lst_end));
                end
              end
            endcase
          end
        end
      end
    endcase

    if (last) begin
      if (ph == PH_REC || ph == PH_HS) st = ST_NOT_HELLO;
      else if (ph == PH_END && held_status == ST_NOT_HELLO) st = ST_NOT_HELLO;
      else if (rec_len + REC_HDR_BYTES > seen) st = ST_NOT_HELLO;
      else if (ph == PH_END) st = held_status;
      else st = ST_MALFORMED;
      r.kind      = RES_STATUS;
      r.name_byte = '0;
      r.name_end  = 1'b0;
      r.status    = st;
      sni_words_due.push_back(r);
      clear_parser();
    end
  endfunction

  initial clear_parser();

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      clear_parser();
      sni_words_due.delete();
    end else begin
      if (in_tvalid && in_tready) parse_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (sni_words_due.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("unexpected word: kind=%0d byte=%02h end=%0d status=%0d",
                     out_tuser[0], out_tdata[7:0], out_tlast, out_tdata[9:8]);
        end else begin
          want = sni_words_due.pop_front();
          if (out_tuser[0] !== want.kind || out_tdata[7:0] !== want.name_byte ||
              out_tlast !== want.name_end || out_tdata[9:8] !== want.status ||
              out_tdata[15:10] !== 6'd0) begin
            fails++;
            if (fails <= MAX_REPORTS) begin
              $write("word mismatch: expected kind=%0d byte=%02h end=%0d status=%0d,",
                     want.kind, want.name_byte, want.name_end, want.status);
              $display(" got kind=%0d byte=%02h end=%0d status=%0d pad=%02h",
                       out_tuser[0], out_tdata[7:0], out_tlast, out_tdata[9:8],
                       out_tdata[15:10]);
            end
          end
        end
      end
    end
    fail_count <= fails;
    words_due  <= sni_words_due.size();
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import tlssni_pkg::*;

  localparam int         CYCLE_LIMIT          = 200000;
  localparam int         RANDOM_BYTES         = 1400;
  localparam int         MIN_BUFFERS          = 16;
  localparam int         DRAIN_CYCLES         = 20;
  localparam logic [7:0] VER_MAJOR            = 8'h03;
  localparam logic [7:0] VER_MINOR            = 8'h01;
  localparam logic [7:0] HS_TYPE_SERVER_HELLO = 8'h02;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [7:0] data_byte
  logic        in_tlast;    // last_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;   // [7:0] name_byte, [9:8] status, [15:10] zero
  logic        out_tlast;   // name_end
  logic [0:0]  out_tuser;   // [0] result_kind

  int fail_count;
  int words_due;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int bend_pct       = 0;
  int cycle_count    = 0;
  int bytes_sent     = 0;
  int buffers_sent   = 0;

  logic [7:0] frame[$];
  logic [7:0] exts[$];
  logic [7:0] names[$];

  // short buffers: bad record type, short headers, wrong handshake type,
  // saturated handshake length, handshake too short for the fixed part
  logic [7:0] directed_bytes [36] = '{
    8'hFF,
    8'h00,
    REC_TYPE_HANDSHAKE,
    REC_TYPE_HANDSHAKE, VER_MAJOR, VER_MINOR, 8'h00, 8'h04, HS_TYPE_SERVER_HELLO, 8'h00,
    REC_TYPE_HANDSHAKE, VER_MAJOR, VER_MINOR, 8'h00, 8'h04, HS_TYPE_CLIENT_HELLO, 8'h00,
    8'h00,
    REC_TYPE_HANDSHAKE, VER_MAJOR, VER_MINOR, 8'hFF, 8'hFF, HS_TYPE_CLIENT_HELLO, 8'hFF,
    8'hFF, 8'hFF,
    REC_TYPE_HANDSHAKE, VER_MAJOR, VER_MINOR, 8'h00, 8'h04, HS_TYPE_CLIENT_HELLO, 8'h00,
    8'h00, 8'h00
  };
  int directed_lens [7] = '{1, 1, 1, 7, 8, 9, 9};

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  tls_client_hello_sni_extract DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  tlssni_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .words_due  (words_due)
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  // bends a length field now and then so that bound checks get hit
  function automatic int warp(input int v);
    if ($urandom_range(99) >= bend_pct) return v;
    case ($urandom_range(0, 3))
      0:       return v + 1;
      1:       return v + $urandom_range(2, 40);
      2:       return (v > 0) ? v - 1 : 0;
      default: return 16'hFFFF;
    endcase
  endfunction

  task automatic make_names();
    int n, i, j, len;
    names.delete();
    n = $urandom_range(0, 3);
    for (i = 0; i < n; i++) begin
      len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
      names.push_back(($urandom_range(0, 3) == 0) ? rnd8() : 8'h00);
      len = warp(len);
      names.push_back(8'(len >> 8));
      names.push_back(8'(len));
      for (j = 0; j < (len & 16'h00FF) && j < 12; j++) names.push_back(rnd8());
    end
  endtask

  task automatic make_exts();
    int n, i, j, len, etype;
    exts.delete();
    n = $urandom_range(0, 3);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) != 0) begin
        make_names();
        exts.push_back(SNI_TYPE[15:8]);
        exts.push_back(SNI_TYPE[7:0]);
        len = warp(names.size() + 2);
        exts.push_back(8'(len >> 8));
        exts.push_back(8'(len));
        len = warp(names.size());
        exts.push_back(8'(len >> 8));
        exts.push_back(8'(len));
        foreach (names[k]) exts.push_back(names[k]);
      end else begin
        etype = $urandom_range(1, 65535);
        len   = $urandom_range(0, 5);
        exts.push_back(8'(etype >> 8));
        exts.push_back(8'(etype));
        exts.push_back(8'(warp(len) >> 8));
        exts.push_back(8'(warp(len)));
        repeat (len) exts.push_back(rnd8());
      end
    end
  endtask

  task automatic make_hello();
    int  sid, cs, comp, body, hl, rl, v;
    bit  has_ext;
    sid     = $urandom_range(0, 3);
    cs      = 2 * $urandom_range(0, 3);
    comp    = $urandom_range(0, 2);
    has_ext = ($urandom_range(0, 5) != 0);
    exts.delete();
    if (has_ext) make_exts();
    body = 34 + 1 + sid + 2 + cs + 1 + comp + (has_ext ? 2 + exts.size() : 0);
    hl   = ($urandom_range(0, 29) == 0) ? 24'hFFFFFF : warp(body);
    rl   = ($urandom_range(0, 29) == 0) ? 16'hFFFF : warp(body + 4);
    frame.delete();
    frame.push_back(REC_TYPE_HANDSHAKE);
    frame.push_back(VER_MAJOR);
    frame.push_back(VER_MINOR);
    frame.push_back(8'(rl >> 8));
    frame.push_back(8'(rl));
    frame.push_back(HS_TYPE_CLIENT_HELLO);
    frame.push_back(8'(hl >> 16));
    frame.push_back(8'(hl >> 8));
    frame.push_back(8'(hl));
    repeat (34) frame.push_back(rnd8());
    frame.push_back(8'(warp(sid)));
    repeat (sid) frame.push_back(rnd8());
    v = warp(cs);
    frame.push_back(8'(v >> 8));
    frame.push_back(8'(v));
    repeat (cs) frame.push_back(rnd8());
    frame.push_back(8'(warp(comp)));
    repeat (comp) frame.push_back(rnd8());
    if (has_ext) begin
      v = warp(exts.size());
      frame.push_back(8'(v >> 8));
      frame.push_back(8'(v));
      foreach (exts[k]) frame.push_back(exts[k]);
    end
  endtask

  task automatic send_frame();
    int i;
    for (i = 0; i < frame.size(); i++) begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= frame[i];
      in_tlast  <= (i == frame.size() - 1);
      do @(posedge clk); while (!in_tready);
    end
    bytes_sent += frame.size();
    buffers_sent++;
  endtask

  initial begin
    int         k, pick, cut;
    logic [15:0] rlen;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tlast  = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    k = 0;
    foreach (directed_lens[d]) begin
      frame.delete();
      repeat (directed_lens[d]) begin
        frame.push_back(directed_bytes[k]);
        k++;
      end
      send_frame();
    end
    bytes_sent = 0;

    while (bytes_sent < RANDOM_BYTES || buffers_sent < MIN_BUFFERS) begin
      // idling mode changes every three buffers
      case ((buffers_sent / 3) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      pick     = $urandom_range(99);
      bend_pct = (pick < 20) ? 20 : 0;
      if (pick >= 94) begin
        // line noise, sometimes with a plausible first byte
        frame.delete();
        repeat ($urandom_range(1, 12)) frame.push_back(rnd8());
        if ($urandom_range(0, 1) == 0) frame[0] = REC_TYPE_HANDSHAKE;
      end else begin
        make_hello();
        if (pick >= 60 && pick < 72) begin
          cut = $urandom_range(1, frame.size());
          while (frame.size() > cut) void'(frame.pop_back());
        end else if (pick >= 72 && pick < 80) begin
          repeat ($urandom_range(1, 5)) frame.push_back(rnd8());
        end else if (pick >= 80 && pick < 85) begin
          frame[0] = rnd8();
        end else if (pick >= 85 && pick < 90) begin
          frame[5] = rnd8();
        end else if (pick >= 90) begin
          rlen     = {frame[3], frame[4]} + 16'($urandom_range(1, 300));
          frame[3] = rlen[15:8];
          frame[4] = rlen[7:0];
        end
      end
      send_frame();
    end
    in_tvalid <= 1'b0;

    do @(posedge clk); while (words_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && words_due == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
